### sv/gmas_pkg.sv
// ----------------------------------------------------------------------------
// gmas_pkg: shared types and constants of the group median age selector
// Group membership table, field widths, queue depth and the record entry
// that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package gmas_pkg;

   // defaults for the top level parameters
   localparam int AGE_LEVELS_DEF = 128;
   localparam int MAX_PEOPLE_DEF = 256;

   // fixed field widths
   localparam int AGE_W  = 7;
   localparam int GID_W  = 3;
   localparam int SIZE_W = 9;

   // categories are is_female * 2 + has_job
   localparam int NUM_CATS   = 4;
   localparam int CAT_W      = 2;
   localparam int NUM_GROUPS = 7;

   // widest row index the back end may need (up to 1024 age levels)
   localparam int ROW_MAX_W = 10;

   // depth of the queue between front and back end (power of two)
   localparam int Q_DEPTH = 4;

   // bit c set: category c belongs to the group
   localparam logic [NUM_CATS-1:0] GROUP_MEMBERS [NUM_GROUPS] = '{
      4'hF,  // all
      4'hC,  // female
      4'h3,  // male
      4'h8,  // female employed
      4'h4,  // female unemployed
      4'h2,  // male employed
      4'h1   // male unemployed
   };

   // one classified request
   typedef struct packed {
      logic [ROW_MAX_W-1:0] row;   // clamped age
      logic [CAT_W-1:0]     cat;   // category lane
      logic                 keep;  // counted, not dropped
      logic                 last;  // closes the set
   } rec_type;

endpackage

### sv/gmas_if.sv
// ----------------------------------------------------------------------------
// gmas_if: request and response channels
// Valid/ready channels carrying one person record and one group result.
// ----------------------------------------------------------------------------
interface gmas_req_if import gmas_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [AGE_W-1:0] age;
   logic             is_female;
   logic             has_job;
   logic             last_record;

   modport source (output valid, age, is_female, has_job, last_record, input ready);
   modport sink   (input valid, age, is_female, has_job, last_record, output ready);
endinterface

interface gmas_rsp_if import gmas_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [GID_W-1:0]  group_id;
   logic [AGE_W-1:0]  median_age;
   logic [SIZE_W-1:0] group_size;
   logic              records_dropped;
   logic              last_result;

   modport source (output valid, group_id, median_age, group_size, records_dropped,
                   last_result, input ready);
   modport sink   (input valid, group_id, median_age, group_size, records_dropped,
                   last_result, output ready);
endinterface

### sv/gmas_front.sv
// ----------------------------------------------------------------------------
// gmas_front: request intake and classification
// Clamps the age, picks the category lane, tracks the set's capacity and
// pushes one classified entry per accepted request into the queue.
// ----------------------------------------------------------------------------
module gmas_front import gmas_pkg::*; #(
   parameter int AGE_LEVELS = AGE_LEVELS_DEF,
   parameter int MAX_PEOPLE = MAX_PEOPLE_DEF
) (
   input  logic       clock,
   input  logic       reset,
   gmas_req_if.sink   req,
   input  logic       clear_busy,
   input  logic       q_ready,
   output logic       q_push,
   output rec_type    q_data
);

   localparam int CW = $clog2(MAX_PEOPLE + 1);

   logic [CW-1:0] total_ff;
   logic [CW-1:0] total_in;
   logic [31:0]   age_ext;
   logic [31:0]   age_clamp;
   logic          keep;

   // hold requests off while the count memory is being cleared
   assign req.ready = q_ready && !clear_busy;
   assign q_push    = req.valid && req.ready;

   // clamp ages beyond the top level
   always_comb begin
      age_ext   = 32'(req.age);
      age_clamp = (age_ext >= 32'(AGE_LEVELS)) ? 32'(AGE_LEVELS - 1) : age_ext;
   end

   assign keep = (32'(total_ff) != 32'(MAX_PEOPLE));

   always_comb begin
      q_data.row  = ROW_MAX_W'(age_clamp);
      q_data.cat  = {req.is_female, req.has_job};
      q_data.keep = keep;
      q_data.last = req.last_record;
   end

   // count kept requests, restart on the last one of a set
   always_comb begin
      total_in = total_ff;
      if (q_push) begin
         if (req.last_record) begin
            total_in = '0;
         end else if (keep) begin
            total_in = total_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
      end
   end

endmodule

### sv/gmas_queue.sv
// ----------------------------------------------------------------------------
// gmas_queue: short FIFO between front and back end
// Lets the front keep taking requests while the back end is busy.
// ----------------------------------------------------------------------------
module gmas_queue import gmas_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rec_type push_data,
   output logic    push_ready,
   input  logic    pop,
   output logic    pop_valid,
   output rec_type pop_data
);

   localparam int PW = $clog2(Q_DEPTH);
   localparam int NW = $clog2(Q_DEPTH + 1);

   rec_type        slot_ff [Q_DEPTH];
   logic [PW-1:0]  wr_ptr_ff;
   logic [PW-1:0]  rd_ptr_ff;
   logic [NW-1:0]  count_ff;
   logic [NW-1:0]  count_in;

   assign push_ready = (count_ff != NW'(Q_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   // advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         count_ff <= count_in;
      end
   end

   // store entries
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### sv/gmas_back.sv
// ----------------------------------------------------------------------------
// gmas_back: count memory, median scan and result output
// Increments one counter per kept entry through a read-modify-write pipeline,
// then on the set's last entry sums the histogram, scans for the seven
// medians while zeroing the memory, and sends the seven results.
// ----------------------------------------------------------------------------
module gmas_back import gmas_pkg::*; #(
   parameter int AGE_LEVELS = AGE_LEVELS_DEF,
   parameter int MAX_PEOPLE = MAX_PEOPLE_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  rec_type    q_data,
   output logic       q_pop,
   output logic       clear_busy,
   gmas_rsp_if.source rsp
);

   localparam int AW = $clog2(AGE_LEVELS);
   localparam int SW = $clog2(AGE_LEVELS + 1);
   localparam int CW = $clog2(MAX_PEOPLE + 1);

   typedef logic [NUM_CATS-1:0][CW-1:0] row_type;

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_LOAD   = 7'b0000010,
      ST_DRAIN  = 7'b0000100,
      ST_SUM    = 7'b0001000,
      ST_SIZE   = 7'b0010000,
      ST_SEARCH = 7'b0100000,
      ST_EMIT   = 7'b1000000
   } state_type;

   // count memory, one row of four category counters per age
   row_type mem [AGE_LEVELS];

   state_type        state_ff;
   logic [SW-1:0]    idx_ff;
   logic [GID_W-1:0] gidx_ff;
   logic             ovf_ff;
   logic             data_vld_ff;
   logic [AW-1:0]    data_age_ff;
   row_type          rd_data_ff;
   logic             fwd_hit_ff;
   row_type          fwd_row_ff;

   logic                 s2_vld_ff;
   logic [AW-1:0]        s2_row_ff;
   logic [CAT_W-1:0]     s2_cat_ff;
   logic                 s2_keep_ff;

   row_type          tot_ff;
   logic [CW-1:0]    size_ff   [NUM_GROUPS];
   logic [CW-1:0]    cum_ff    [NUM_GROUPS];
   logic [AW-1:0]    median_ff [NUM_GROUPS];
   logic [NUM_GROUPS-1:0] found_ff;

   logic              rsp_vld_ff;
   logic [GID_W-1:0]  rsp_gid_ff;
   logic [AGE_W-1:0]  rsp_med_ff;
   logic [SIZE_W-1:0] rsp_size_ff;
   logic              rsp_drop_ff;
   logic              rsp_last_ff;

   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   row_type       wr_data;
   row_type       cur_row;
   row_type       upd_row;
   logic          scan_live;
   logic          rsp_load;

   logic [CW-1:0] row_cnt [NUM_GROUPS];
   logic [CW-1:0] cum_sum [NUM_GROUPS];
   logic [NUM_GROUPS-1:0] hit;

   // sum the counters of the categories in a group
   function automatic logic [CW-1:0] grp_sum(logic [NUM_CATS-1:0] members, row_type r);
      logic [CW-1:0] acc;
      acc = '0;
      for (int c = 0; c < NUM_CATS; c++) begin
         if (members[c]) begin
            acc = acc + r[c];
         end
      end
      return acc;
   endfunction

   assign clear_busy = (state_ff == ST_CLEAR);
   assign scan_live  = (idx_ff != SW'(AGE_LEVELS));
   assign rsp_load   = (state_ff == ST_EMIT) && (!rsp_vld_ff || rsp.ready);

   // increment one lane of the row, with the previous write forwarded
   always_comb begin
      cur_row = fwd_hit_ff ? fwd_row_ff : rd_data_ff;
      upd_row = cur_row;
      upd_row[s2_cat_ff] = cur_row[s2_cat_ff] + CW'(1);
   end

   // memory port control
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = q_data.row[AW-1:0];
      wr_en   = 1'b0;
      wr_addr = s2_row_ff;
      wr_data = upd_row;
      q_pop   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            wr_data = '0;
         end
         ST_LOAD: begin
            q_pop = q_valid;
            rd_en = q_valid;
            wr_en = s2_vld_ff && s2_keep_ff;
         end
         ST_DRAIN: begin
            wr_en = s2_vld_ff && s2_keep_ff;
         end
         ST_SUM: begin
            rd_en   = scan_live;
            rd_addr = idx_ff[AW-1:0];
         end
         ST_SEARCH: begin
            rd_en   = scan_live;
            rd_addr = idx_ff[AW-1:0];
            wr_en   = scan_live;
            wr_addr = idx_ff[AW-1:0];
            wr_data = '0;
         end
         ST_SIZE, ST_EMIT: begin
         end
         default: begin
         end
      endcase
   end

   // memory access, read before write at the same address
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // per-group cumulative count and median test
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         row_cnt[g] = grp_sum(GROUP_MEMBERS[g], rd_data_ff);
         cum_sum[g] = cum_ff[g] + row_cnt[g];
         hit[g]     = !found_ff[g] && (cum_sum[g] > (size_ff[g] >> 1));
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         idx_ff      <= '0;
         gidx_ff     <= '0;
         ovf_ff      <= 1'b0;
         data_vld_ff <= 1'b0;
         s2_vld_ff   <= 1'b0;
         fwd_hit_ff  <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         s2_vld_ff   <= q_pop;
         data_vld_ff <= rd_en && (state_ff == ST_SUM || state_ff == ST_SEARCH);
         fwd_hit_ff  <= wr_en && rd_en && (wr_addr == rd_addr);
         if (q_pop && !q_data.keep) begin
            ovf_ff <= 1'b1;
         end
         if (rsp_vld_ff && rsp.ready && !rsp_load) begin
            rsp_vld_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               if (idx_ff == SW'(AGE_LEVELS - 1)) begin
                  idx_ff   <= '0;
                  state_ff <= ST_LOAD;
               end else begin
                  idx_ff <= idx_ff + SW'(1);
               end
            end
            ST_LOAD: begin
               if (q_pop && q_data.last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               idx_ff   <= '0;
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               if (scan_live) begin
                  idx_ff <= idx_ff + SW'(1);
               end else begin
                  idx_ff   <= '0;
                  state_ff <= ST_SIZE;
               end
            end
            ST_SIZE: begin
               state_ff <= ST_SEARCH;
            end
            ST_SEARCH: begin
               if (scan_live) begin
                  idx_ff <= idx_ff + SW'(1);
               end else begin
                  idx_ff   <= '0;
                  gidx_ff  <= '0;
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (rsp_load) begin
                  rsp_vld_ff <= 1'b1;
                  gidx_ff    <= gidx_ff + GID_W'(1);
                  if (gidx_ff == GID_W'(NUM_GROUPS - 1)) begin
                     ovf_ff   <= 1'b0;
                     state_ff <= ST_LOAD;
                  end
               end
            end
            default: begin
               state_ff <= ST_CLEAR;
            end
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      fwd_row_ff <= wr_data;
      if (q_pop) begin
         s2_row_ff  <= q_data.row[AW-1:0];
         s2_cat_ff  <= q_data.cat;
         s2_keep_ff <= q_data.keep;
      end
      if (rd_en) begin
         data_age_ff <= idx_ff[AW-1:0];
      end
      // clear category totals before the sum pass
      if (state_ff == ST_DRAIN) begin
         tot_ff <= '0;
      end
      if (state_ff == ST_SUM && data_vld_ff) begin
         for (int c = 0; c < NUM_CATS; c++) begin
            tot_ff[c] <= tot_ff[c] + rd_data_ff[c];
         end
      end
      // form group sizes and restart the median search
      if (state_ff == ST_SIZE) begin
         for (int g = 0; g < NUM_GROUPS; g++) begin
            size_ff[g]   <= grp_sum(GROUP_MEMBERS[g], tot_ff);
            cum_ff[g]    <= '0;
            median_ff[g] <= '0;
         end
         found_ff <= '0;
      end
      if (state_ff == ST_SEARCH && data_vld_ff) begin
         for (int g = 0; g < NUM_GROUPS; g++) begin
            cum_ff[g] <= cum_sum[g];
            if (hit[g]) begin
               found_ff[g]  <= 1'b1;
               median_ff[g] <= data_age_ff;
            end
         end
      end
      // load the output register
      if (rsp_load) begin
         rsp_gid_ff  <= gidx_ff;
         rsp_med_ff  <= AGE_W'(32'(median_ff[gidx_ff]));
         rsp_size_ff <= SIZE_W'(32'(size_ff[gidx_ff]));
         rsp_drop_ff <= ovf_ff;
         rsp_last_ff <= (gidx_ff == GID_W'(NUM_GROUPS - 1));
      end
   end

   assign rsp.valid           = rsp_vld_ff;
   assign rsp.group_id        = rsp_gid_ff;
   assign rsp.median_age      = rsp_med_ff;
   assign rsp.group_size      = rsp_size_ff;
   assign rsp.records_dropped = rsp_drop_ff;
   assign rsp.last_result     = rsp_last_ff;

   // the histogram is not written during the sum pass, the size step or the output phase
   a_no_write_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM || state_ff == ST_SIZE || state_ff == ST_EMIT) |-> !wr_en)
      else $error("count memory written outside load, clear or search");

   // the second pipeline stage only follows a pop in the load phase
   a_s2_after_load: assert property (@(posedge clock) disable iff (reset)
      s2_vld_ff |-> $past(state_ff) == ST_LOAD)
      else $error("increment stage active without a pop");

   // the whole set splits into female and male
   a_size_split: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |->
         (32'(size_ff[0]) == 32'(size_ff[1]) + 32'(size_ff[2])))
      else $error("group sizes inconsistent");

   // leaving the output phase leaves the final result in the register
   a_last_on_exit: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == ST_EMIT && state_ff == ST_LOAD) |-> (rsp_vld_ff && rsp_last_ff))
      else $error("output phase ended without the final result");

endmodule

### sv/group_median_age_selector_unit.sv
// ----------------------------------------------------------------------------
// group_median_age_selector_unit: upper median age per group, by histogram
// Counts person records per category and age, and on the last record of a
// set reports seven group medians with sizes and a dropped flag.
// ----------------------------------------------------------------------------
// Records are taken one per cycle while the queue has room and no clearing
// pass runs: each goes through a four-entry queue into a read-modify-write
// pipeline on the count memory (AGE_LEVELS rows of four counters) that
// completes one increment per cycle in the load phase. The record marked
// last starts the close of the set: a drain step, a sum pass, a step to
// form group sizes, a search pass that also zeroes the memory, and the
// seven results, sent as the response side takes them. Up to four records
// of the next set are queued meanwhile. After reset a clearing pass over all
// AGE_LEVELS rows runs, during which no request is accepted.
// ----------------------------------------------------------------------------
module group_median_age_selector_unit import gmas_pkg::*; #(
   parameter int AGE_LEVELS = AGE_LEVELS_DEF,
   parameter int MAX_PEOPLE = MAX_PEOPLE_DEF
) (
   input  logic       clock,
   input  logic       reset,
   gmas_req_if.sink   req,
   gmas_rsp_if.source rsp
);

   logic    clear_busy;
   logic    q_push;
   logic    q_ready;
   rec_type q_push_data;
   logic    q_pop;
   logic    q_valid;
   rec_type q_pop_data;

   // classify incoming requests
   gmas_front #(
      .AGE_LEVELS (AGE_LEVELS),
      .MAX_PEOPLE (MAX_PEOPLE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .clear_busy (clear_busy),
      .q_ready    (q_ready),
      .q_push     (q_push),
      .q_data     (q_push_data)
   );

   // decouple intake from the count engine
   gmas_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_data),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_data   (q_pop_data)
   );

   // count, scan and report
   gmas_back #(
      .AGE_LEVELS (AGE_LEVELS),
      .MAX_PEOPLE (MAX_PEOPLE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (q_pop_data),
      .q_pop      (q_pop),
      .clear_busy (clear_busy),
      .rsp        (rsp)
   );

endmodule

### tb/group_median_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// group_median_checker: result predictor and scoreboard
// Watches the request and response channels, keeps its own age histogram per
// category, predicts the seven group results of each closed set and compares
// every accepted response, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module group_median_checker import gmas_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   gmas_req_if         req_mon,
   gmas_rsp_if         rsp_mon,
   input  logic        run_done,
   output int unsigned outstanding,
   output int unsigned fail_count
);

   localparam int LEVELS   = AGE_LEVELS_DEF;
   localparam int CAPACITY = MAX_PEOPLE_DEF;

   typedef struct packed {
      logic [GID_W-1:0]  group_id;
      logic [AGE_W-1:0]  median_age;
      logic [SIZE_W-1:0] group_size;
      logic              records_dropped;
      logic              last_result;
   } group_result_type;

   // histogram of the set being loaded
   int unsigned      age_hist [NUM_CATS][LEVELS];
   int unsigned      people_loaded;
   logic             capacity_hit;
   group_result_type expected_results [$];
   int unsigned      errors;
   logic             leftovers_checked;

   // print one line per mismatch and count it
   task automatic report_mismatch(input string msg);
      errors++;
      $display("%0t ns: %s", $time, msg);
   endtask

   function automatic void clear_set();
      for (int c = 0; c < NUM_CATS; c++)
         for (int a = 0; a < LEVELS; a++) age_hist[c][a] = 0;
      people_loaded = 0;
      capacity_hit  = 1'b0;
   endfunction

   // size and upper median (rank n/2) of one group over the histogram
   function automatic group_result_type summarize_group(input int g);
      group_result_type r;
      int unsigned      n;
      int unsigned      cum;
      bit               found;
      n = 0;
      for (int a = 0; a < LEVELS; a++)
         for (int c = 0; c < NUM_CATS; c++)
            if (GROUP_MEMBERS[g][c]) n += age_hist[c][a];
      r.group_id        = GID_W'(g);
      r.group_size      = SIZE_W'(n);
      r.median_age      = '0;
      r.records_dropped = capacity_hit;
      r.last_result     = (g == NUM_GROUPS - 1);
      cum   = 0;
      found = 1'b0;
      if (n != 0) begin
         for (int a = 0; a < LEVELS; a++) begin
            for (int c = 0; c < NUM_CATS; c++)
               if (GROUP_MEMBERS[g][c]) cum += age_hist[c][a];
            if (!found && cum > n / 2) begin
               r.median_age = AGE_W'(a);
               found = 1'b1;
            end
         end
      end
      return r;
   endfunction

   // count one request; on the last of the set queue the seven results
   function automatic void take_record(input logic [AGE_W-1:0] age, input logic fem,
                                       input logic emp, input logic last);
      int row;
      int cat;
      row = (age >= LEVELS) ? LEVELS - 1 : int'(age);
      cat = fem * 2 + emp;
      if (people_loaded >= CAPACITY) begin
         capacity_hit = 1'b1;
      end else begin
         age_hist[cat][row]++;
         people_loaded++;
      end
      if (last) begin
         for (int g = 0; g < NUM_GROUPS; g++) expected_results.push_back(summarize_group(g));
         clear_set();
      end
   endfunction

   always @(posedge clock) begin
      group_result_type got;
      group_result_type want;
      if (reset) begin
         clear_set();
         expected_results.delete();
         errors            = 0;
         leftovers_checked = 1'b0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            take_record(req_mon.age, req_mon.is_female, req_mon.has_job,
                        req_mon.last_record);

         // compare each accepted response with the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.group_id, rsp_mon.median_age, rsp_mon.group_size,
                    rsp_mon.records_dropped, rsp_mon.last_result};
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("unexpected response: group %0d median %0d size %0d",
                                         got.group_id, got.median_age, got.group_size));
            end else begin
               want = expected_results.pop_front();
               if (got.group_id !== want.group_id)
                  report_mismatch($sformatf("group_id: got %0d, expected %0d",
                                            got.group_id, want.group_id));
               if (got.median_age !== want.median_age)
                  report_mismatch($sformatf("group %0d median_age: got %0d, expected %0d",
                                            want.group_id, got.median_age, want.median_age));
               if (got.group_size !== want.group_size)
                  report_mismatch($sformatf("group %0d group_size: got %0d, expected %0d",
                                            want.group_id, got.group_size, want.group_size));
               if (got.records_dropped !== want.records_dropped)
                  report_mismatch($sformatf("group %0d records_dropped: got %b, expected %b",
                                            want.group_id, got.records_dropped,
                                            want.records_dropped));
               if (got.last_result !== want.last_result)
                  report_mismatch($sformatf("group %0d last_result: got %b, expected %b",
                                            want.group_id, got.last_result, want.last_result));
            end
         end

         // flag predictions that never arrived
         if (run_done && !leftovers_checked) begin
            leftovers_checked = 1'b1;
            if (expected_results.size() != 0)
               report_mismatch($sformatf("%0d predicted responses never arrived",
                                         expected_results.size()));
         end
      end
      outstanding <= expected_results.size();
      fail_count  <= errors;
   end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top of the group median age selector
// Drives person records in sets (directed corner sets, then random sets of
// mostly small size plus one set past capacity), stalls both channels in
// random bursts, and gives the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb import gmas_pkg::*; ();

   localparam int HALF_PERIOD    = 5;
   localparam int RESET_CYCLES   = 4;
   localparam int RANDOM_ITEMS   = 340;
   localparam int CALM_AFTER     = 300;
   localparam int OVERFLOW_AT    = 40;
   localparam int DRAIN_CYCLES   = 2 * AGE_LEVELS_DEF + 40;
   localparam int WATCHDOG_LIMIT = 3000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        run_done = 1'b0;
   int unsigned outstanding;
   int unsigned fail_count;
   int unsigned quiet_cycles = 0;
   int unsigned stall_left = 0;
   int unsigned gap_pct = 0;
   int unsigned stall_pct = 0;
   bit          calm = 1'b0;

   gmas_req_if req_ch ();
   gmas_rsp_if rsp_ch ();

   group_median_age_selector_unit u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   group_median_checker u_chk (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .run_done    (run_done),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   always #HALF_PERIOD clock = ~clock;

   // hold response ready low in random bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left   <= stall_left - 1;
         rsp_ch.ready <= (stall_left == 1);
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
         stall_left   <= $urandom_range(1, 14);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // end the run when nothing is accepted for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // present one request, with an optional idle burst first, and wait for it
   task automatic send_person(input logic [AGE_W-1:0] age, input logic fem,
                              input logic emp, input logic last);
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.age         <= age;
      req_ch.is_female   <= fem;
      req_ch.has_job     <= emp;
      req_ch.last_record <= last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // one random set: ages spread or bunched, categories free or restricted
   task automatic send_random_set(input int n);
      bit                bunched;
      int                mix;
      int                base;
      logic [AGE_W-1:0]  age;
      logic              fem;
      logic              emp;
      bunched = ($urandom_range(0, 2) == 0);
      mix     = $urandom_range(0, 3);
      base    = $urandom_range(0, 124);
      for (int i = 0; i < n; i++) begin
         age = bunched ? AGE_W'($urandom_range(base, base + 3)) : AGE_W'($urandom_range(0, 127));
         fem = 1'($urandom_range(0, 1));
         emp = 1'($urandom_range(0, 1));
         case (mix)
            1: fem = 1'b1;
            2: fem = 1'b0;
            3: begin
               fem = 1'b0;
               emp = 1'b1;
            end
            default: ;
         endcase
         send_person(age, fem, emp, i == n - 1);
      end
   endtask

   initial begin
      int  sent;
      int  n;
      bit  overflow_done;
      req_ch.valid       <= 1'b0;
      req_ch.age         <= '0;
      req_ch.is_female   <= 1'b0;
      req_ch.has_job     <= 1'b0;
      req_ch.last_record <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // single record sets at both age extremes
      send_person(7'd0, 1'b0, 1'b0, 1'b1);
      send_person(7'd127, 1'b1, 1'b1, 1'b1);
      // one record per category
      send_person(7'd10, 1'b0, 1'b0, 1'b0);
      send_person(7'd20, 1'b0, 1'b1, 1'b0);
      send_person(7'd30, 1'b1, 1'b0, 1'b0);
      send_person(7'd40, 1'b1, 1'b1, 1'b1);
      // even count with ties at the extremes
      send_person(7'd127, 1'b0, 1'b1, 1'b0);
      send_person(7'd0, 1'b1, 1'b0, 1'b0);
      send_person(7'd127, 1'b1, 1'b0, 1'b0);
      send_person(7'd0, 1'b0, 1'b1, 1'b0);
      send_person(7'd64, 1'b1, 1'b1, 1'b0);
      send_person(7'd63, 1'b0, 1'b0, 1'b1);
      // females only: male groups empty
      send_person(7'd85, 1'b1, 1'b1, 1'b0);
      send_person(7'd42, 1'b1, 1'b0, 1'b0);
      send_person(7'd42, 1'b1, 1'b1, 1'b0);
      send_person(7'd1, 1'b1, 1'b0, 1'b0);
      send_person(7'd126, 1'b1, 1'b1, 1'b1);

      // random sets, one of them past capacity; quiet channels at the end
      sent          = 0;
      overflow_done = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         calm = (sent >= CALM_AFTER);
         case ($urandom_range(0, 2))
            0: gap_pct = 0;
            1: gap_pct = 10;
            default: gap_pct = 40;
         endcase
         case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 8;
            default: stall_pct = 30;
         endcase
         if (!overflow_done && sent >= OVERFLOW_AT) begin
            n = MAX_PEOPLE_DEF + $urandom_range(1, 6);
            overflow_done = 1'b1;
         end else if ($urandom_range(0, 7) == 0) begin
            n = $urandom_range(13, 40);
         end else begin
            n = $urandom_range(1, 12);
         end
         send_random_set(n);
         sent += n;
      end
      req_ch.valid <= 1'b0;

      // drain the predictions, then watch for stray responses
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      run_done <= 1'b1;
      repeat (2) @(posedge clock);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### files.f
sv/gmas_pkg.sv
sv/gmas_if.sv
sv/gmas_front.sv
sv/gmas_queue.sv
sv/gmas_back.sv
sv/group_median_age_selector_unit.sv
tb/group_median_checker.sv
tb/tb.sv
